@@ design/rar_pkg.sv @@
package rar_pkg;

    // operation codes
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_CMP = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture input word
        logic       mul;       // run one product
        logic [1:0] mul_sel;   // which product
        logic       form;      // build n/d, settle special cases
        logic       gcd_step;  // one binary GCD step
        logic       gcd_fix;   // g = u << k, arm dividers
        logic       div_step;  // one quotient bit on both dividers
    } rar_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic special;   // result settled in form step
        logic gcd_done;  // u == v
    } rar_sts_t;

endpackage

@@ design/rar_dp.sv @@
module rar_dp
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                     clk,
    input  rar_cmd_t                 cmd,
    output rar_sts_t                 sts,
    input  logic [2:0]               mode,
    input  logic [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-1:0] a_den,
    input  logic [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-1:0] b_den,
    output logic [32:0]              res_num,
    output logic [30:0]              res_den,
    output logic                     is_equal,
    output logic                     err_zero_den
);

    localparam int OW = OPERAND_WIDTH + 1;      // operand magnitude
    localparam int MW = 2 * OPERAND_WIDTH + 2;  // product / sum magnitude
    localparam int KW = $clog2(MW);
    localparam int XW = (MW + 1 > 33) ? MW + 1 : 33;
    localparam int DW = (MW > 31) ? MW : 31;

    // captured operands, sign-magnitude
    logic [2:0]    mode_reg;
    logic [OW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic          an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;

    // products
    logic [MW-1:0] p0_reg, p1_reg, p2_reg;
    logic          p0_neg_reg, p1_neg_reg, p2_neg_reg;

    // reduction
    logic [MW-1:0] u_reg, v_reg, g_reg;
    logic [KW-1:0] k_reg;
    logic [MW-1:0] qn_reg, qd_reg, rn_reg, rd_reg;
    logic          neg_reg, eq_reg, err_reg;

    function automatic logic [OW-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
        logic [OW-1:0] x;
        x = {v[OPERAND_WIDTH-1], v};
        return v[OPERAND_WIDTH-1] ? OW'(-x) : x;
    endfunction

    // shared multiplier, operands picked by step
    logic [OW-1:0] mx, my;
    logic          mxn, myn;
    logic [MW-1:0] prod;
    logic          prod_neg;

    always_comb
    begin
        mx  = ad_reg;
        mxn = ad_neg_reg;
        my  = bd_reg;
        myn = bd_neg_reg;
        unique case (cmd.mul_sel)
            2'd0:
            begin
                mx  = an_reg;
                mxn = an_neg_reg;
                my  = (mode_reg == MODE_MUL) ? bn_reg : bd_reg;
                myn = (mode_reg == MODE_MUL) ? bn_neg_reg : bd_neg_reg;
            end
            2'd1:
            begin
                my  = (mode_reg == MODE_MUL) ? bd_reg : bn_reg;
                myn = (mode_reg == MODE_MUL) ? bd_neg_reg : bn_neg_reg;
            end
            default:
            begin
                my  = bd_reg;
                myn = bd_neg_reg;
            end
        endcase
        prod     = MW'(mx) * MW'(my);
        prod_neg = (mxn ^ myn) && (prod != '0);
    end

    // form n and d from the products
    logic          op_zero;
    logic [MW-1:0] n_mag, d_mag;
    logic          n_neg, d_neg, t_neg, cmp_eq;

    always_comb
    begin
        op_zero = (ad_reg == '0) || (bd_reg == '0);
        cmp_eq  = (p0_reg == p1_reg) && (p0_neg_reg == p1_neg_reg);
        t_neg   = (mode_reg == MODE_SUB) ? (p1_neg_reg ^ (p1_reg != '0)) : p1_neg_reg;
        if (mode_reg == MODE_ADD || mode_reg == MODE_SUB)
        begin
            d_mag = p2_reg;
            d_neg = p2_neg_reg;
            if (p0_neg_reg == t_neg)
            begin
                n_mag = p0_reg + p1_reg;
                n_neg = p0_neg_reg;
            end
            else if (p0_reg >= p1_reg)
            begin
                n_mag = p0_reg - p1_reg;
                n_neg = p0_neg_reg;
            end
            else
            begin
                n_mag = p1_reg - p0_reg;
                n_neg = t_neg;
            end
        end
        else
        begin
            n_mag = p0_reg;
            n_neg = p0_neg_reg;
            d_mag = p1_reg;
            d_neg = p1_neg_reg;
        end
        sts.special = op_zero || (mode_reg > MODE_DIV) || (d_mag == '0) || (n_mag == '0);
        sts.gcd_done = (u_reg == v_reg);
    end

    // divider trial subtraction, both dividers in step
    logic [MW:0] tn, td;
    logic        gen, ged;

    always_comb
    begin
        tn  = {rn_reg, qn_reg[MW-1]};
        td  = {rd_reg, qd_reg[MW-1]};
        gen = tn >= {1'b0, g_reg};
        ged = td >= {1'b0, g_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            an_reg     <= mag_of(a_num);
            ad_reg     <= mag_of(a_den);
            bn_reg     <= mag_of(b_num);
            bd_reg     <= mag_of(b_den);
            an_neg_reg <= a_num[OPERAND_WIDTH-1];
            ad_neg_reg <= a_den[OPERAND_WIDTH-1];
            bn_neg_reg <= b_num[OPERAND_WIDTH-1];
            bd_neg_reg <= b_den[OPERAND_WIDTH-1];
        end

        if (cmd.mul)
        begin
            unique case (cmd.mul_sel)
                2'd0:
                begin
                    p0_reg     <= prod;
                    p0_neg_reg <= prod_neg;
                end
                2'd1:
                begin
                    p1_reg     <= prod;
                    p1_neg_reg <= prod_neg;
                end
                default:
                begin
                    p2_reg     <= prod;
                    p2_neg_reg <= prod_neg;
                end
            endcase
        end

        // settle specials or seed the GCD
        if (cmd.form)
        begin
            qn_reg  <= '0;
            qd_reg  <= MW'(1);
            neg_reg <= 1'b0;
            eq_reg  <= 1'b0;
            err_reg <= 1'b0;
            u_reg   <= n_mag;
            v_reg   <= d_mag;
            k_reg   <= '0;
            if (op_zero)
            begin
                err_reg <= (mode_reg <= MODE_CMP);
            end
            else if (mode_reg == MODE_CMP)
            begin
                eq_reg <= cmp_eq;
            end
            else if (mode_reg <= MODE_DIV)
            begin
                if (d_mag == '0)
                begin
                    err_reg <= 1'b1;
                end
                else if (n_mag != '0)
                begin
                    qn_reg  <= n_mag;
                    qd_reg  <= d_mag;
                    neg_reg <= n_neg ^ d_neg;
                end
            end
        end

        // binary GCD step
        if (cmd.gcd_step)
        begin
            priority if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_reg <= (u_reg - v_reg) >> 1;
            end
            else
            begin
                v_reg <= (v_reg - u_reg) >> 1;
            end
        end

        if (cmd.gcd_fix)
        begin
            g_reg  <= u_reg << k_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end

        // restoring division, one bit per cycle
        if (cmd.div_step)
        begin
            rn_reg <= gen ? MW'(tn - {1'b0, g_reg}) : MW'(tn);
            rd_reg <= ged ? MW'(td - {1'b0, g_reg}) : MW'(td);
            qn_reg <= {qn_reg[MW-2:0], gen};
            qd_reg <= {qd_reg[MW-2:0], ged};
        end
    end

    // result fields, truncated to port widths
    logic [MW:0]   num_s;
    logic [XW-1:0] num_x;
    logic [DW-1:0] den_x;

    always_comb
    begin
        num_s        = neg_reg ? (MW+1)'(-{1'b0, qn_reg}) : {1'b0, qn_reg};
        num_x        = XW'($signed(num_s));
        den_x        = DW'(qd_reg);
        res_num      = num_x[32:0];
        res_den      = den_x[30:0];
        is_equal     = eq_reg;
        err_zero_den = err_reg;
    end

endmodule

@@ design/rar_ctrl.sv @@
module rar_ctrl
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output logic     out_load,
    output rar_cmd_t cmd,
    input  rar_sts_t sts
);

    localparam int MW = 2 * OPERAND_WIDTH + 2;
    localparam int CW = $clog2(MW + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_FORM = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_FIX  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul  = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(2))
                begin
                    state_next = S_FORM;
                end
            end
            S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = sts.special ? S_DONE : S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_FIX:
            begin
                cmd.gcd_fix = 1'b1;
                cnt_next    = CW'(MW);
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/rational_arith_reduce.sv @@
// Rational arithmetic with reduction to lowest terms.
// Input channel (in_valid / in_stall) carries one word: mode, a_num, a_den,
// b_num, b_den. Output channel (out_valid / out_stall) returns one word per
// input: res_num, res_den (always positive), is_equal, err_zero_den.
// Modes: add, subtract, multiply, divide, equality compare.
// One word is worked at a time. After accept, the three products run on one
// shared multiplier, then the form step, then the binary GCD at one step
// per cycle until a cycle sees u == v; then the divisor is built, bit-serial
// division finds 2*OPERAND_WIDTH+2 quotient bits and the word goes into the
// output register. Compare, error, zero and undefined-mode results skip the
// GCD and division.
// in_stall is high while a word is in work. A finished word sits in the
// output register while out_stall is high; the next input is taken meanwhile
// and waits at its last step until the register frees up.
// Reset clears the controller and drops out_valid; no other state is kept.
module rational_arith_reduce
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               mode,
    input  logic [OPERAND_WIDTH-1:0] a_num,
    input  logic [OPERAND_WIDTH-1:0] a_den,
    input  logic [OPERAND_WIDTH-1:0] b_num,
    input  logic [OPERAND_WIDTH-1:0] b_den,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [32:0]              res_num,
    output logic [30:0]              res_den,
    output logic                     is_equal,
    output logic                     err_zero_den
);

    rar_cmd_t    cmd;
    rar_sts_t    sts;
    logic        out_load;
    logic [32:0] dp_num;
    logic [30:0] dp_den;
    logic        dp_eq, dp_err;

    // output word register
    logic [32:0] res_num_reg;
    logic [30:0] res_den_reg;
    logic        is_equal_reg, err_reg;

    rar_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_load  (out_load),
        .cmd       (cmd),
        .sts       (sts)
    );

    rar_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .a_num        (a_num),
        .a_den        (a_den),
        .b_num        (b_num),
        .b_den        (b_den),
        .res_num      (dp_num),
        .res_den      (dp_den),
        .is_equal     (dp_eq),
        .err_zero_den (dp_err)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_num_reg  <= dp_num;
            res_den_reg  <= dp_den;
            is_equal_reg <= dp_eq;
            err_reg      <= dp_err;
        end
    end

    assign res_num      = res_num_reg;
    assign res_den      = res_den_reg;
    assign is_equal     = is_equal_reg;
    assign err_zero_den = err_reg;

endmodule

@@ verif/rational_arith_reduce_tb.sv @@
module rational_arith_reduce_tb;
    import rar_pkg::*;

    localparam int W = 16;
    localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
    localparam int N_RANDOM = 1230;
    localparam int N_DIRECTED = 20;

    typedef struct packed {
        logic [2:0]   mode;
        logic [W-1:0] a_num;
        logic [W-1:0] a_den;
        logic [W-1:0] b_num;
        logic [W-1:0] b_den;
    } frac_word_t;

    typedef struct packed {
        logic [32:0] num;
        logic [30:0] den;
        logic        eq;
        logic        err;
    } frac_res_t;

    typedef struct packed {
        frac_word_t w;
        bit         typed;
        frac_res_t  r;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [2:0]       mode;
    logic [W-1:0]     a_num, a_den, b_num, b_den;
    logic             out_valid;
    logic             out_stall;
    logic [32:0]      res_num;
    logic [30:0]      res_den;
    logic             is_equal;
    logic             err_zero_den;

    frac_res_t        pending_q[$];
    int               err_count = 0;
    int               tx_idle = 31;
    int               rx_idle = 49;

    rational_arith_reduce #(.OPERAND_WIDTH(W)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_num(res_num), .res_den(res_den),
        .is_equal(is_equal), .err_zero_den(err_zero_den)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // lowest terms of n/d (d nonzero), sign on the numerator, zero as 0/1
    function automatic void lowest_terms(longint n, longint d,
                                         output longint rn, output longint rd);
        longint unsigned mn, md, g;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        if (mn == 0)
        begin
            rn = 0;
            rd = 1;
            return;
        end
        g = euclid_gcd(mn, md);
        rn = longint'(mn / g);
        if ((n < 0) != (d < 0))
            rn = -rn;
        rd = longint'(md / g);
    endfunction

    function automatic frac_res_t rational_result(frac_word_t w);
        frac_res_t r;
        longint an, ad, bn, bd, n, d, rn, rd, xn, xd, yn, yd;
        an = longint'($signed(w.a_num));
        ad = longint'($signed(w.a_den));
        bn = longint'($signed(w.b_num));
        bd = longint'($signed(w.b_den));
        rn = 0;
        rd = 1;
        r.eq = 1'b0;
        r.err = 1'b0;
        if (ad == 0 || bd == 0)
        begin
            r.err = (w.mode <= MODE_CMP);
        end
        else if (w.mode == MODE_CMP)
        begin
            lowest_terms(an, ad, xn, xd);
            lowest_terms(bn, bd, yn, yd);
            r.eq = (xn == yn && xd == yd);
        end
        else if (w.mode <= MODE_DIV)
        begin
            case (w.mode)
                MODE_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
                MODE_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
                MODE_MUL: begin n = an * bn; d = ad * bd; end
                default:  begin n = an * bd; d = ad * bn; end
            endcase
            if (d == 0)
                r.err = 1'b1;
            else
                lowest_terms(n, d, rn, rd);
        end
        r.num = rn[32:0];
        r.den = rd[30:0];
        return r;
    endfunction

    // ---------------- output side ----------------
    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        err_count++;
    endtask

    initial
    begin
        frac_res_t want;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                    report("unexpected word", 1, 0);
                else
                begin
                    want = pending_q.pop_front();
                    if (res_num !== want.num)
                        report("res_num", $signed(res_num), $signed(want.num));
                    if (res_den !== want.den)
                        report("res_den", res_den, want.den);
                    if (is_equal !== want.eq)
                        report("is_equal", is_equal, want.eq);
                    if (err_zero_den !== want.err)
                        report("err_zero_den", err_zero_den, want.err);
                end
            end
            out_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    // ---------------- input side ----------------
    // present one word and hold it until taken
    task automatic send_word(frac_word_t w, bit typed, frac_res_t r);
        in_valid <= 1'b1;
        mode  <= w.mode;
        a_num <= w.a_num;
        a_den <= w.a_den;
        b_num <= w.b_num;
        b_den <= w.b_den;
        do
            @(posedge clk);
        while (in_stall);
        pending_q.push_back(typed ? r : rational_result(w));
        if ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(7))
            0:       return W'($urandom_range(15));
            1:       return -W'($urandom_range(15));
            2:       return W'($urandom_range(1, 255)) * W'($urandom_range(1, 127));
            default: return W'($urandom);
        endcase
    endfunction

    function automatic frac_word_t rand_word();
        frac_word_t w;
        logic [W-1:0] k;
        int pick;
        pick = $urandom_range(99);
        w.mode  = (pick < 4) ? 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI))
                             : 3'($urandom_range(MODE_ADD, MODE_CMP));
        w.a_num = rand_operand();
        w.a_den = rand_operand();
        w.b_num = rand_operand();
        w.b_den = rand_operand();
        // equal fractions in scaled form for the compare
        if (w.mode == MODE_CMP && $urandom_range(1))
        begin
            w.a_num = W'($urandom_range(0, 200)) - W'(100);
            w.a_den = W'($urandom_range(1, 150));
            k = $urandom_range(1) ? W'($urandom_range(1, 100)) : -W'($urandom_range(1, 100));
            w.b_num = w.a_num * k;
            w.b_den = w.a_den * k;
        end
        return w;
    endfunction

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{'{MODE_ADD, 16'd1, 16'd2, 16'd1, 16'd3}, 1'b0, '0},
        '{'{MODE_SUB, 16'd1, 16'd2, 16'd3, -16'd4}, 1'b0, '0},
        '{'{MODE_MUL, -16'd6, 16'd35, 16'd14, 16'd9}, 1'b0, '0},
        '{'{MODE_DIV, 16'd3, 16'd8, -16'd9, 16'd4}, 1'b0, '0},
        '{'{MODE_CMP, 16'd2, 16'd4, -16'd3, -16'd6}, 1'b1, '{33'd0, 31'd1, 1'b1, 1'b0}},
        '{'{MODE_CMP, 16'd1, 16'd2, 16'd1, 16'd3}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b0}},
        '{'{MODE_CMP, 16'd0, 16'd5, 16'd0, -16'd7}, 1'b1, '{33'd0, 31'd1, 1'b1, 1'b0}},
        '{'{MODE_ADD, 16'd1, 16'd0, 16'd1, 16'd3}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b1}},
        '{'{MODE_CMP, 16'd1, 16'd2, 16'd1, 16'd0}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b1}},
        '{'{MODE_MUL, 16'd5, 16'd0, 16'd0, 16'd0}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b1}},
        '{'{MODE_DIV, 16'd7, 16'd3, 16'd0, 16'd5}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b1}},
        '{'{MODE_MUL, 16'd0, 16'd5, 16'd7, 16'd3}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b0}},
        '{'{MODE_SUB, 16'd4, 16'd6, 16'd2, 16'd3}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b0}},
        '{'{MODE_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1,
          '{33'd1, 31'd1, 1'b0, 1'b0}},
        '{'{MODE_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1}, 1'b1,
          '{33'd1073741824, 31'd1, 1'b0, 1'b0}},
        '{'{MODE_ADD, 16'h8000, 16'd1, 16'h8000, 16'd1}, 1'b0, '0},
        '{'{MODE_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff}, 1'b0, '0},
        '{'{MODE_DIV, 16'd1, 16'h8000, 16'h7fff, 16'h8000}, 1'b0, '0},
        '{'{MODE_UNDEF_LO, 16'd3, 16'd4, 16'd5, 16'd6}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b0}},
        '{'{MODE_UNDEF_HI, 16'd3, 16'd0, 16'd5, 16'd6}, 1'b1, '{33'd0, 31'd1, 1'b0, 1'b0}}
    };

    initial
    begin
        int i;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_ADD;
        a_num     = '0;
        a_den     = '0;
        b_num     = '0;
        b_den     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words
        for (i = 0; i < N_DIRECTED; i++)
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

        // random words, idling swaps after a third and stops after two thirds
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                tx_idle = 49;
                rx_idle = 31;
            end
            else if (i == 2 * N_RANDOM / 3)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            send_word(rand_word(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
